@@ rtl/hwbp_pkg.sv @@
// ---------------------------------------------------------------------------
// Hardware breakpoint slot manager: shared definitions
// Command, kind, access type and status codes, the length and kind mappings
// and the control structures passed between the top level and the slot file.
// ---------------------------------------------------------------------------
package hwbp_pkg;

    localparam int SLOT_COUNT_DEFAULT = 4;
    localparam int HIT_FLAG_W         = 4;
    localparam int ADDR_W             = 64;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [3:0] KIND_SOFTWARE = 4'd0;
    localparam logic [3:0] KIND_EXEC     = 4'd1;
    localparam logic [3:0] KIND_WRITE    = 4'd2;
    localparam logic [3:0] KIND_READ     = 4'd3;
    localparam logic [3:0] KIND_ACCESS   = 4'd4;

    localparam logic [2:0] TYPE_EXEC  = 3'd0;
    localparam logic [2:0] TYPE_WRITE = 3'd1;
    localparam logic [2:0] TYPE_READ  = 3'd2;
    localparam logic [2:0] TYPE_RW    = 3'd3;
    localparam logic [2:0] TYPE_SW    = 3'd4;

    localparam logic [1:0] LEN_CODE_1 = 2'd0;
    localparam logic [1:0] LEN_CODE_2 = 2'd1;
    localparam logic [1:0] LEN_CODE_8 = 2'd2;
    localparam logic [1:0] LEN_CODE_4 = 2'd3;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_UNSUPPORTED = 3'd1;
    localparam logic [2:0] STATUS_BAD_KIND    = 3'd2;
    localparam logic [2:0] STATUS_NO_SLOT     = 3'd3;
    localparam logic [2:0] STATUS_BAD_ARG     = 3'd4;

    typedef struct packed {
        logic [1:0]        access;
        logic [1:0]        length_code;
        logic [ADDR_W-1:0] address;
    } t_slot_key;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_slot_ctrl;

    typedef struct packed {
        logic              free_found;
        logic              match_found;
        logic [2:0]        hit_number;
        logic [1:0]        hit_access;
        logic [ADDR_W-1:0] hit_address;
    } t_slot_look;

    function automatic logic [1:0] len_code(input logic [7:0] n);
        logic [1:0] code;
        unique case (n)
            8'd1:    code = LEN_CODE_1;
            8'd2:    code = LEN_CODE_2;
            8'd4:    code = LEN_CODE_4;
            default: code = LEN_CODE_8;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] kind_code(input logic [3:0] kind);
        logic [2:0] t;
        unique case (kind)
            KIND_EXEC:   t = TYPE_EXEC;
            KIND_WRITE:  t = TYPE_WRITE;
            KIND_READ:   t = TYPE_READ;
            KIND_ACCESS: t = TYPE_RW;
            default:     t = TYPE_SW;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/hw_breakpoint_slot_manager.sv @@
// ---------------------------------------------------------------------------
// The input word is held in the input register and the result word in the
// result register. Throughput: one command per cycle while the output is not
// stalled; the slot lookup and update lies combinationally between them.
// Reset: synchronous, active low; all slots are cleared and both registers
// are emptied.
// ---------------------------------------------------------------------------
// Hardware breakpoint slot manager
// Inserts, removes and reports hits on debug-register style breakpoint and
// watchpoint slots.
// ---------------------------------------------------------------------------
module hw_breakpoint_slot_manager #(
    parameter int SLOT_COUNT = hwbp_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_watch_kind,
    input  logic [63:0] i_address,
    input  logic [7:0]  i_length_bytes,
    input  logic [3:0]  i_hit_flags,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [1:0]  o_slot,
    output logic [2:0]  o_hit_number,
    output logic [1:0]  o_hit_access,
    output logic [63:0] o_hit_address
);
    import hwbp_pkg::*;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                  r_in_valid;
    logic [1:0]            r_func;
    logic [3:0]            r_watch_kind;
    logic [ADDR_W-1:0]     r_address;
    logic [7:0]            r_length_bytes;
    logic [HIT_FLAG_W-1:0] r_hit_flags;

    logic                  r_out_valid;
    logic [2:0]            r_status;
    logic [1:0]            r_slot;
    logic [2:0]            r_hit_number;
    logic [1:0]            r_hit_access;
    logic [ADDR_W-1:0]     r_hit_address;

    logic [2:0]            n_status;
    logic [1:0]            n_slot;
    logic [2:0]            n_hit_number;
    logic [1:0]            n_hit_access;
    logic [ADDR_W-1:0]     n_hit_address;

    logic                  out_free;
    logic                  advance;
    logic                  accept;
    logic [2:0]            kind_type;
    t_slot_key             key;
    t_slot_ctrl            ctrl;
    t_slot_ctrl            op;
    t_slot_look            look;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic [SLOT_IDX_W-1:0] ctrl_idx;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign kind_type       = kind_code(r_watch_kind);
    assign key.access      = kind_type[1:0];
    assign key.length_code = len_code(r_length_bytes);
    assign key.address     = r_address;

    always_comb begin
        n_status      = STATUS_OK;
        n_slot        = '0;
        n_hit_number  = '0;
        n_hit_access  = '0;
        n_hit_address = '0;
        op            = '0;
        unique case (r_func)
            FUNC_INSERT: begin
                priority if (r_watch_kind > KIND_ACCESS) begin
                    n_status = STATUS_BAD_KIND;
                end else if (!look.free_found) begin
                    n_status = STATUS_NO_SLOT;
                end else if (kind_type == TYPE_EXEC && key.length_code != LEN_CODE_1) begin
                    n_status = STATUS_BAD_ARG;
                end else if (kind_type == TYPE_READ || kind_type == TYPE_SW) begin
                    n_status = STATUS_UNSUPPORTED;
                end else begin
                    op.wr  = 1'b1;
                    n_slot = 2'(free_idx);
                end
            end
            FUNC_REMOVE: begin
                priority if (r_watch_kind > KIND_ACCESS) begin
                    n_status = STATUS_BAD_KIND;
                end else if (kind_type == TYPE_READ || kind_type == TYPE_SW) begin
                    n_status = STATUS_UNSUPPORTED;
                end else if (!look.match_found) begin
                    n_status = STATUS_NO_SLOT;
                end else begin
                    op.clr = 1'b1;
                    n_slot = 2'(match_idx);
                end
            end
            FUNC_QUERY: begin
                n_hit_number  = look.hit_number;
                n_hit_access  = look.hit_access;
                n_hit_address = look.hit_address;
            end
            default: begin
                n_status = STATUS_BAD_ARG;
            end
        endcase
    end

    assign ctrl.wr  = op.wr && advance;
    assign ctrl.clr = op.clr && advance;
    assign ctrl_idx = op.wr ? free_idx : match_idx;

    hwbp_slot_file #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_file (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key),
        .i_ctrl      (ctrl),
        .i_ctrl_idx  (ctrl_idx),
        .i_hit_flags (r_hit_flags),
        .o_look      (look),
        .o_free_idx  (free_idx),
        .o_match_idx (match_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_func         <= i_func;
            r_watch_kind   <= i_watch_kind;
            r_address      <= i_address;
            r_length_bytes <= i_length_bytes;
            r_hit_flags    <= i_hit_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_status      <= n_status;
            r_slot        <= n_slot;
            r_hit_number  <= n_hit_number;
            r_hit_access  <= n_hit_access;
            r_hit_address <= n_hit_address;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_hit_number  = r_hit_number;
    assign o_hit_access  = r_hit_access;
    assign o_hit_address = r_hit_address;

    a_slot_only_on_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STATUS_OK |-> o_slot == '0)
        else $error("slot reported on a failed command");

    a_no_hit_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit_number == '0 |-> o_hit_access == '0 && o_hit_address == '0)
        else $error("hit details reported without a hit");

    a_stall_only_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall && r_in_valid)
        else $error("input stalled while the result register can move");

endmodule

@@ rtl/hwbp_slot_file.sv @@
// ---------------------------------------------------------------------------
// Hardware breakpoint slot file
// Holds the slots, finds the lowest free slot, the lowest matching enabled
// slot and the lowest hit slot, and writes or clears one slot per cycle.
// ---------------------------------------------------------------------------
module hwbp_slot_file #(
    parameter int SLOT_COUNT = hwbp_pkg::SLOT_COUNT_DEFAULT,
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hwbp_pkg::t_slot_key                 i_key,
    input  hwbp_pkg::t_slot_ctrl                i_ctrl,
    input  logic [SLOT_IDX_W-1:0]               i_ctrl_idx,
    input  logic [hwbp_pkg::HIT_FLAG_W-1:0]     i_hit_flags,
    output hwbp_pkg::t_slot_look                o_look,
    output logic [SLOT_IDX_W-1:0]               o_free_idx,
    output logic [SLOT_IDX_W-1:0]               o_match_idx
);
    import hwbp_pkg::*;

    localparam int HIT_LIM = (SLOT_COUNT < HIT_FLAG_W) ? SLOT_COUNT : HIT_FLAG_W;

    logic [ADDR_W-1:0] r_address     [SLOT_COUNT];
    logic              r_enabled     [SLOT_COUNT];
    logic [1:0]        r_access      [SLOT_COUNT];
    logic [1:0]        r_length_code [SLOT_COUNT];

    always_comb begin
        o_look      = '0;
        o_free_idx  = '0;
        o_match_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_enabled[i]) begin
                o_look.free_found = 1'b1;
                o_free_idx        = SLOT_IDX_W'(i);
            end
            if (r_enabled[i] && r_length_code[i] == i_key.length_code &&
                r_access[i] == i_key.access && r_address[i] == i_key.address) begin
                o_look.match_found = 1'b1;
                o_match_idx        = SLOT_IDX_W'(i);
            end
        end
        for (int i = HIT_LIM - 1; i >= 0; i--) begin
            if (i_hit_flags[i]) begin
                o_look.hit_number  = 3'(i + 1);
                o_look.hit_access  = r_access[i];
                o_look.hit_address = r_address[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_address[i]     <= '0;
                r_enabled[i]     <= 1'b0;
                r_access[i]      <= '0;
                r_length_code[i] <= '0;
            end
        end else if (i_ctrl.wr) begin
            r_address[i_ctrl_idx]     <= i_key.address;
            r_enabled[i_ctrl_idx]     <= 1'b1;
            r_access[i_ctrl_idx]      <= i_key.access;
            r_length_code[i_ctrl_idx] <= i_key.length_code;
        end else if (i_ctrl.clr) begin
            r_address[i_ctrl_idx]     <= '0;
            r_enabled[i_ctrl_idx]     <= 1'b0;
            r_access[i_ctrl_idx]      <= '0;
            r_length_code[i_ctrl_idx] <= '0;
        end
    end

    a_wr_free_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.wr |-> o_look.free_found && !r_enabled[i_ctrl_idx])
        else $error("slot written while already enabled");

    a_clr_enabled_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clr |-> o_look.match_found && r_enabled[i_ctrl_idx])
        else $error("slot cleared while not enabled");

    a_wr_clr_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.wr |-> !i_ctrl.clr)
        else $error("slot written and cleared in the same cycle");

endmodule
